// File: design/pva_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Voice allocator package
// Request codes, the state machine type and the reserved pitch shared by the
// allocator and its voice record store.
// ----------------------------------------------------------------------------
package pva_pkg;

   // Request codes on req_cmd.
   localparam logic [1:0] CMD_ASSIGN_NOTE  = 2'd0;
   localparam logic [1:0] CMD_ASSIGN_VOICE = 2'd1;
   localparam logic [1:0] CMD_KILL_NOTE    = 2'd2;
   localparam logic [1:0] CMD_KILL_VOICE   = 2'd3;

   // Reserved pitch, also the marker of a voice that holds no note.
   localparam logic [15:0] NO_PITCH = 16'h8000;

   // Voice number returned when a request is rejected or finds nothing.
   localparam logic [6:0] VOICE_NONE = 7'h7F;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE
   } state_type;

endpackage
`default_nettype wire

// File: design/pva_rec_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Voice record store
// One record per voice: pitch, list membership and position within its list.
// Read data is registered; a voice never written since reset reads as a free
// voice holding no note at the list position equal to its own number.
// ----------------------------------------------------------------------------
module pva_rec_store #(
   parameter int VOICES = 8,
   parameter int IW     = 3
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          rd_en,
   input  wire logic [IW-1:0] rd_addr,
   input  wire logic          wr_en,
   input  wire logic [IW-1:0] wr_addr,
   input  wire logic [15:0]   wr_pitch,
   input  wire logic          wr_busy,
   input  wire logic [IW-1:0] wr_rank,
   output logic               rd_vld,
   output logic [IW-1:0]      rd_idx,
   output logic [15:0]        rd_pitch,
   output logic               rd_busy,
   output logic [IW-1:0]      rd_rank
);

   localparam int REC_W = 16 + 1 + IW;

   logic [REC_W-1:0]  rec_mem [VOICES];
   logic [VOICES-1:0] written_ff;
   logic [REC_W-1:0]  rd_data_ff;
   logic              rd_init_ff;
   logic [IW-1:0]     rd_idx_ff;
   logic              rd_vld_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         rec_mem[wr_addr] <= {wr_pitch, wr_busy, wr_rank};
      end
      if (rd_en) begin
         rd_data_ff <= rec_mem[rd_addr];
         rd_init_ff <= written_ff[rd_addr];
         rd_idx_ff  <= rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
         rd_vld_ff  <= 1'b0;
      end else begin
         rd_vld_ff <= rd_en;
         if (wr_en) begin
            written_ff[wr_addr] <= 1'b1;
         end
      end
   end

   assign rd_vld   = rd_vld_ff;
   assign rd_idx   = rd_idx_ff;
   assign rd_pitch = rd_init_ff ? rd_data_ff[REC_W-1 -: 16] : pva_pkg::NO_PITCH;
   assign rd_busy  = rd_init_ff ? rd_data_ff[IW] : 1'b0;
   assign rd_rank  = rd_init_ff ? rd_data_ff[IW-1:0] : rd_idx_ff;

endmodule
`default_nettype wire

// File: design/poly_voice_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Polyphonic voice allocator
// Hands synthesizer voices out to note pitches, stealing the oldest busy
// voice when none is free.
// ----------------------------------------------------------------------------
// A request (req_cmd, req_pitch, req_voice_index) is taken at a clock edge
// where start is high and busy is low. Every request gives exactly one
// response: rsp_valid is high for a single cycle with rsp_voice_out and
// rsp_accepted, and the receiver must take it then.
// A request with the reserved pitch or a voice out of range is answered in
// the cycle after it is taken, and busy stays low.
// Any other request walks the voice records through one shared compare and
// update path: a search pass of up to VOICES reads, stopping at the first
// match, then an update pass over all VOICES records that closes the gap in
// the list the voice leaves and appends it to the list it joins. When the
// response comes depends on where the search stops; a kill by note that
// finds nothing is answered at the end of the search pass, with no update.
// Busy is high until the response cycle, so the next request can be taken
// at the edge that ends it. The record store has a single read port, so
// both passes read the records one at a time.
// Reset leaves every voice free, in numerical order, holding no note; the
// response strobe is low after reset.
// ----------------------------------------------------------------------------
module poly_voice_allocator #(
   parameter int VOICES = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_cmd,
   input  wire logic signed [15:0] req_pitch,
   input  wire logic signed [7:0]  req_voice_index,
   output logic             rsp_valid,
   output logic signed [6:0] rsp_voice_out,
   output logic             rsp_accepted
);

   localparam int IW = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int CW = $clog2(VOICES + 1);
   localparam logic [CW-1:0] CNT_ALL  = CW'(VOICES);
   localparam logic [IW-1:0] IDX_LAST = IW'(VOICES - 1);

   pva_pkg::state_type state_ff, state_in;

   logic [CW-1:0]  iss_ff, iss_in;
   logic [1:0]     cmd_ff, cmd_in;
   logic [15:0]    pitch_ff, pitch_in;
   logic [IW-1:0]  vi_ff, vi_in;
   logic [IW-1:0]  tgt_ff, tgt_in;
   logic           tgt_busy_ff, tgt_busy_in;
   logic [IW-1:0]  tgt_rank_ff, tgt_rank_in;
   logic [CW-1:0]  busy_cnt_ff, busy_cnt_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [6:0]     rsp_voice_ff, rsp_voice_in;
   logic           rsp_acc_ff, rsp_acc_in;

   logic          rd_en, wr_en;
   logic [15:0]   wr_pitch;
   logic          wr_busy;
   logic [IW-1:0] wr_rank;
   logic          rd_vld, rd_busy;
   logic [IW-1:0] rd_idx, rd_rank;
   logic [15:0]   rd_pitch;

   logic          accept, reject, pitch_bad, vi_bad;
   logic          match, found, scan_end, upd_last;
   logic          src_busy, new_busy;
   logic [CW-1:0] dest_cnt;

   pva_rec_store #(
      .VOICES (VOICES),
      .IW     (IW)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (rd_en),
      .rd_addr  (iss_ff[IW-1:0]),
      .wr_en    (wr_en),
      .wr_addr  (rd_idx),
      .wr_pitch (wr_pitch),
      .wr_busy  (wr_busy),
      .wr_rank  (wr_rank),
      .rd_vld   (rd_vld),
      .rd_idx   (rd_idx),
      .rd_pitch (rd_pitch),
      .rd_busy  (rd_busy),
      .rd_rank  (rd_rank)
   );

   assign accept    = start && (state_ff == pva_pkg::ST_IDLE);
   assign pitch_bad = (req_pitch == pva_pkg::NO_PITCH);
   assign vi_bad    = !($unsigned(req_voice_index) < 8'(VOICES));

   always_comb begin
      case (req_cmd)
         pva_pkg::CMD_ASSIGN_NOTE:  reject = pitch_bad;
         pva_pkg::CMD_ASSIGN_VOICE: reject = pitch_bad || vi_bad;
         pva_pkg::CMD_KILL_NOTE:    reject = pitch_bad;
         default:                   reject = vi_bad;
      endcase
   end

   // With no free voice left, the oldest busy voice is the one stolen.
   assign src_busy = (busy_cnt_ff == CNT_ALL);
   assign new_busy = (cmd_ff == pva_pkg::CMD_ASSIGN_NOTE) ||
                     (cmd_ff == pva_pkg::CMD_ASSIGN_VOICE);

   always_comb begin
      case (cmd_ff)
         pva_pkg::CMD_ASSIGN_NOTE: match = (rd_busy == src_busy) && (rd_rank == '0);
         pva_pkg::CMD_KILL_NOTE:   match = (rd_pitch == pitch_ff);
         default:                  match = (rd_idx == vi_ff);
      endcase
   end

   assign found    = rd_vld && match;
   assign scan_end = (iss_ff == CNT_ALL) && !rd_vld;
   assign upd_last = rd_vld && (rd_idx == IDX_LAST);

   // The voice joins the young end of its new list, whose length first drops
   // by one if the voice is leaving that same list.
   always_comb begin
      dest_cnt = new_busy ? busy_cnt_ff : (CNT_ALL - busy_cnt_ff);
      if (tgt_busy_ff == new_busy) begin
         dest_cnt = dest_cnt - CW'(1);
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pva_pkg::ST_IDLE: begin
            if (accept && !reject) begin
               state_in = pva_pkg::ST_SCAN;
            end
         end
         pva_pkg::ST_SCAN: begin
            if (found) begin
               state_in = pva_pkg::ST_UPDATE;
            end else if (scan_end) begin
               state_in = pva_pkg::ST_IDLE;
            end
         end
         pva_pkg::ST_UPDATE: begin
            if (upd_last) begin
               state_in = pva_pkg::ST_IDLE;
            end
         end
         default: state_in = pva_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      iss_in       = iss_ff;
      cmd_in       = cmd_ff;
      pitch_in     = pitch_ff;
      vi_in        = vi_ff;
      tgt_in       = tgt_ff;
      tgt_busy_in  = tgt_busy_ff;
      tgt_rank_in  = tgt_rank_ff;
      busy_cnt_in  = busy_cnt_ff;
      rsp_valid_in = 1'b0;
      rsp_voice_in = rsp_voice_ff;
      rsp_acc_in   = rsp_acc_ff;
      rd_en        = 1'b0;
      wr_en        = 1'b0;
      wr_pitch     = rd_pitch;
      wr_busy      = rd_busy;
      wr_rank      = rd_rank;
      case (state_ff)
         pva_pkg::ST_IDLE: begin
            if (accept) begin
               cmd_in   = req_cmd;
               pitch_in = req_pitch;
               vi_in    = req_voice_index[IW-1:0];
               iss_in   = '0;
               if (reject) begin
                  rsp_valid_in = 1'b1;
                  rsp_voice_in = pva_pkg::VOICE_NONE;
                  rsp_acc_in   = 1'b0;
               end
            end
         end
         pva_pkg::ST_SCAN: begin
            rd_en = (iss_ff != CNT_ALL) && !found;
            if (rd_en) begin
               iss_in = iss_ff + CW'(1);
            end
            if (found) begin
               tgt_in      = rd_idx;
               tgt_busy_in = rd_busy;
               tgt_rank_in = rd_rank;
               iss_in      = '0;
            end else if (scan_end) begin
               rsp_valid_in = 1'b1;
               rsp_voice_in = pva_pkg::VOICE_NONE;
               rsp_acc_in   = 1'b0;
            end
         end
         pva_pkg::ST_UPDATE: begin
            rd_en = (iss_ff != CNT_ALL);
            if (rd_en) begin
               iss_in = iss_ff + CW'(1);
            end
            if (rd_vld) begin
               wr_en = 1'b1;
               if (rd_idx == tgt_ff) begin
                  wr_pitch = new_busy ? pitch_ff : pva_pkg::NO_PITCH;
                  wr_busy  = new_busy;
                  wr_rank  = dest_cnt[IW-1:0];
               end else if ((rd_busy == tgt_busy_ff) && (rd_rank > tgt_rank_ff)) begin
                  wr_rank = rd_rank - IW'(1);
               end
            end
            if (upd_last) begin
               if (new_busy && !tgt_busy_ff) begin
                  busy_cnt_in = busy_cnt_ff + CW'(1);
               end else if (!new_busy && tgt_busy_ff) begin
                  busy_cnt_in = busy_cnt_ff - CW'(1);
               end
               rsp_valid_in = 1'b1;
               rsp_voice_in = {{(7 - IW){1'b0}}, tgt_ff};
               rsp_acc_in   = 1'b1;
            end
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pva_pkg::ST_IDLE;
         busy_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         iss_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         busy_cnt_ff  <= busy_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         iss_ff       <= iss_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      pitch_ff     <= pitch_in;
      vi_ff        <= vi_in;
      tgt_ff       <= tgt_in;
      tgt_busy_ff  <= tgt_busy_in;
      tgt_rank_ff  <= tgt_rank_in;
      rsp_voice_ff <= rsp_voice_in;
      rsp_acc_ff   <= rsp_acc_in;
   end

   assign busy          = (state_ff != pva_pkg::ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_voice_out = rsp_voice_ff;
   assign rsp_accepted  = rsp_acc_ff;

endmodule
`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voice allocator testbench
// Drives assign and kill requests into the allocator and checks every
// response against a behavioural copy of the voice lists. A short table of
// hand-picked requests comes first, then random traffic in three phases with
// different amounts of sender idling.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int NUM_VOICES = 8;
   localparam int CLK_PERIOD = 10;
   localparam int DIR_ROWS   = 25;
   localparam int MAX_SHOWN  = 10;

   typedef struct packed {
      logic [6:0] voice;
      logic       accepted;
   } alloc_result_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [15:0] pitch;
      logic [7:0]  vidx;
      logic        typed;
      logic [6:0]  voice;
      logic        accepted;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_cmd = '0;
   logic [15:0] req_pitch = '0;
   logic [7:0]  req_voice_index = '0;
   logic        rsp_valid;
   logic [6:0]  rsp_voice_out;
   logic        rsp_accepted;

   // Behavioural copy of the allocator state.
   logic [15:0] voice_pitch [NUM_VOICES];
   int          busy_voices [$];   // start order, oldest first
   int          free_voices [$];   // release order, oldest first

   alloc_result_type pending_results [$];
   int               mismatches = 0;
   logic [15:0]      pitch_pool [8];

   // Rows with a typed result are the ones that can be read off directly:
   // the first note after reset, every rejected request and a kill that finds nothing.
   stim_row_type directed_rows [DIR_ROWS] = '{
      '{pva_pkg::CMD_ASSIGN_NOTE,  16'h7FFF, 8'h00, 1'b1, 7'd0, 1'b1},
      '{pva_pkg::CMD_ASSIGN_NOTE,  pva_pkg::NO_PITCH, 8'h00, 1'b1,
        pva_pkg::VOICE_NONE, 1'b0},
      '{pva_pkg::CMD_ASSIGN_NOTE,  16'h8001, 8'h00, 1'b0, pva_pkg::VOICE_NONE, 1'b0},
      '{pva_pkg::CMD_ASSIGN_NOTE,  16'h0000, 8'hFF, 1'b0, pva_pkg::VOICE_NONE, 1'b0},
      '{pva_pkg::CMD_ASSIGN_NOTE,  16'hFFFF, 8'h80, 1'b0, pva_pkg::VOICE_NONE, 1'b0},
      '{pva_pkg::CMD_ASSIGN_VOICE, 16'h0064, 8'h07, 1'b0, pva_pkg::VOICE_NONE, 1'b0},
      '{pva_pkg::CMD_ASSIGN_VOICE, 16'h00C8, 8'h00, 1'b0, pva_pkg::VOICE_NONE, 1'b0},
      '{pva_pkg::CMD_ASSIGN_VOICE, pva_pkg::NO_PITCH, 8'h02, 1'b1,
        pva_pkg::VOICE_NONE, 1'b0},
      '{pva_pkg::CMD_ASSIGN_VOICE, 16'h012C, 8'h80, 1'b1, pva_pkg::VOICE_NONE, 1'b0},
      '{pva_pkg::CMD_ASSIGN_VOICE, 16'h012C, 8'h7F, 1'b1, pva_pkg::VOICE_NONE, 1'b0},
      '{pva_pkg::CMD_ASSIGN_VOICE, 16'h012C, 8'h08, 1'b1, pva_pkg::VOICE_NONE, 1'b0},
      '{pva_pkg::CMD_KILL_NOTE,    pva_pkg::NO_PITCH, 8'h00, 1'b1,
        pva_pkg::VOICE_NONE, 1'b0},
      '{pva_pkg::CMD_KILL_NOTE,    16'h1234, 8'h00, 1'b1, pva_pkg::VOICE_NONE, 1'b0},
      '{pva_pkg::CMD_KILL_NOTE,    16'h0000, 8'h00, 1'b0, pva_pkg::VOICE_NONE, 1'b0},
      '{pva_pkg::CMD_KILL_VOICE,   16'h0000, 8'h03, 1'b0, pva_pkg::VOICE_NONE, 1'b0},
      '{pva_pkg::CMD_KILL_VOICE,   16'h7FFF, 8'hFF, 1'b1, pva_pkg::VOICE_NONE, 1'b0},
      '{pva_pkg::CMD_KILL_VOICE,   16'h0000, 8'h08, 1'b1, pva_pkg::VOICE_NONE, 1'b0},
      '{pva_pkg::CMD_ASSIGN_VOICE, 16'h0064, 8'h05, 1'b0, pva_pkg::VOICE_NONE, 1'b0},
      '{pva_pkg::CMD_KILL_NOTE,    16'h0064, 8'h00, 1'b0, pva_pkg::VOICE_NONE, 1'b0},
      '{pva_pkg::CMD_ASSIGN_NOTE,  16'h0200, 8'h00, 1'b0, pva_pkg::VOICE_NONE, 1'b0},
      '{pva_pkg::CMD_ASSIGN_NOTE,  16'h0201, 8'h00, 1'b0, pva_pkg::VOICE_NONE, 1'b0},
      '{pva_pkg::CMD_ASSIGN_NOTE,  16'h0202, 8'h00, 1'b0, pva_pkg::VOICE_NONE, 1'b0},
      '{pva_pkg::CMD_ASSIGN_NOTE,  16'h0203, 8'h00, 1'b0, pva_pkg::VOICE_NONE, 1'b0},
      '{pva_pkg::CMD_ASSIGN_NOTE,  16'h0204, 8'h00, 1'b0, pva_pkg::VOICE_NONE, 1'b0},
      '{pva_pkg::CMD_ASSIGN_NOTE,  16'h0205, 8'h00, 1'b0, pva_pkg::VOICE_NONE, 1'b0}
   };

   poly_voice_allocator #(
      .VOICES(NUM_VOICES)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_cmd         (req_cmd),
      .req_pitch       (req_pitch),
      .req_voice_index (req_voice_index),
      .rsp_valid       (rsp_valid),
      .rsp_voice_out   (rsp_voice_out),
      .rsp_accepted    (rsp_accepted)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Take a voice out of whichever list currently holds it.
   function automatic void unlink_voice(input int v);
      bit found;
      found = 1'b0;
      for (int i = 0; i < busy_voices.size(); i++) begin
         if (!found && busy_voices[i] == v) begin
            busy_voices.delete(i);
            found = 1'b1;
         end
      end
      for (int i = 0; i < free_voices.size(); i++) begin
         if (!found && free_voices[i] == v) begin
            free_voices.delete(i);
            found = 1'b1;
         end
      end
   endfunction

   function automatic void take_voice(input int v, input logic [15:0] pitch);
      unlink_voice(v);
      busy_voices.push_back(v);
      voice_pitch[v] = pitch;
   endfunction

   function automatic void retire_voice(input int v);
      unlink_voice(v);
      free_voices.push_back(v);
      voice_pitch[v] = pva_pkg::NO_PITCH;
   endfunction

   function automatic alloc_result_type allocate_voice(input logic [1:0] cmd,
                                                       input logic [15:0] pitch,
                                                       input logic signed [7:0] vidx);
      alloc_result_type res;
      int v;
      int vi;
      bit in_range;
      res.voice    = pva_pkg::VOICE_NONE;
      res.accepted = 1'b0;
      v            = -1;
      vi           = int'(vidx);
      in_range     = (vi >= 0) && (vi < NUM_VOICES);
      case (cmd)
         pva_pkg::CMD_ASSIGN_NOTE: begin
            if (pitch != pva_pkg::NO_PITCH) begin
               // Steal the oldest busy voice only when the free list is empty.
               if (free_voices.size() != 0)
                  v = free_voices.pop_front();
               else
                  v = busy_voices.pop_front();
               take_voice(v, pitch);
            end
         end
         pva_pkg::CMD_ASSIGN_VOICE: begin
            if (pitch != pva_pkg::NO_PITCH && in_range) begin
               v = vi;
               take_voice(v, pitch);
            end
         end
         pva_pkg::CMD_KILL_NOTE: begin
            if (pitch != pva_pkg::NO_PITCH) begin
               for (int i = 0; i < NUM_VOICES; i++)
                  if (v < 0 && voice_pitch[i] == pitch)
                     v = i;
               if (v >= 0)
                  retire_voice(v);
            end
         end
         default: begin
            if (in_range) begin
               v = vi;
               retire_voice(v);
            end
         end
      endcase
      if (v >= 0) begin
         res.voice    = 7'(v);
         res.accepted = 1'b1;
      end
      return res;
   endfunction

   // Present one request, hold it until the allocator takes it, then record
   // what it should answer.
   task automatic issue_request(input logic [1:0] cmd, input logic [15:0] pitch,
                                input logic [7:0] vidx, input int idle_pct,
                                input bit typed, input alloc_result_type typed_res);
      alloc_result_type res;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start           <= 1'b1;
      req_cmd         <= cmd;
      req_pitch       <= pitch;
      req_voice_index <= vidx;
      do @(posedge clock); while (busy);
      res = allocate_voice(cmd, pitch, vidx);
      if (typed)
         res = typed_res;
      pending_results.push_back(res);
   endtask

   task automatic wait_for_responses();
      start <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   // Random traffic drawing pitches mostly from a small pool and from the pitches
   // currently held, so that kill requests can find something and duplicates arise.
   task automatic random_phase(input int count, input int idle_pct);
      logic [1:0]  cmd;
      logic [15:0] pitch;
      logic [7:0]  vidx;
      int          sel;
      for (int n = 0; n < count; n++) begin
         sel = $urandom_range(99);
         if (sel < 35)
            cmd = pva_pkg::CMD_ASSIGN_NOTE;
         else if (sel < 55)
            cmd = pva_pkg::CMD_ASSIGN_VOICE;
         else if (sel < 80)
            cmd = pva_pkg::CMD_KILL_NOTE;
         else
            cmd = pva_pkg::CMD_KILL_VOICE;
         sel = $urandom_range(99);
         if (sel < 4)
            pitch = pva_pkg::NO_PITCH;
         else if (sel < 20)
            pitch = 16'($urandom_range(16'hFFFF));
         else if (sel < 55)
            pitch = voice_pitch[$urandom_range(NUM_VOICES - 1)];
         else
            pitch = pitch_pool[$urandom_range(7)];
         if ($urandom_range(99) < 12)
            vidx = 8'($urandom_range(255));
         else
            vidx = 8'($urandom_range(NUM_VOICES - 1));
         issue_request(cmd, pitch, vidx, idle_pct, 1'b0, '0);
      end
   endtask

   always @(posedge clock) begin : check_responses
      alloc_result_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_results.size() == 0) begin
            if (mismatches < MAX_SHOWN)
               $display("%0t: response with no request waiting: voice %0d accepted %b",
                        $realtime, $signed(rsp_voice_out), rsp_accepted);
            mismatches = mismatches + 1;
         end else begin
            want = pending_results.pop_front();
            if (rsp_voice_out !== want.voice || rsp_accepted !== want.accepted) begin
               if (mismatches < MAX_SHOWN)
                  $display("%0t: voice exp %0d got %0d, accepted exp %b got %b",
                           $realtime, $signed(want.voice), $signed(rsp_voice_out),
                           want.accepted, rsp_accepted);
               mismatches = mismatches + 1;
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("FAILURE");
      $finish;
   end

   initial begin
      for (int i = 0; i < NUM_VOICES; i++) begin
         voice_pitch[i] = pva_pkg::NO_PITCH;
         free_voices.push_back(i);
      end
      for (int i = 0; i < 8; i++) begin
         pitch_pool[i] = 16'($urandom_range(16'hFFFF));
         if (pitch_pool[i] == pva_pkg::NO_PITCH)
            pitch_pool[i] = 16'h8001;
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < DIR_ROWS; r++)
         issue_request(directed_rows[r].cmd, directed_rows[r].pitch,
                       directed_rows[r].vidx, 17, directed_rows[r].typed,
                       {directed_rows[r].voice, directed_rows[r].accepted});
      wait_for_responses();

      random_phase(600, 17);
      wait_for_responses();
      random_phase(600, 56);
      wait_for_responses();
      random_phase(475, 0);
      wait_for_responses();

      repeat (2 * NUM_VOICES + 8) @(posedge clock);
      mismatches = mismatches + pending_results.size();
      if (mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
